@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: shared assertion wrappers for the tga decoder core
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TGAD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgad: same-cycle check failed");

// next-cycle implication
`define TGAD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgad: next-cycle check failed");

`endif

@@ rtl/core/tgad_pkg.sv @@
// ----------------------------------------------------------------------------
// tgad_pkg
// types, codes and helpers shared by the tga decoder core
// ----------------------------------------------------------------------------
`default_nettype none

package tgad_pkg;

    localparam int HDR_LEN = 18;

    localparam logic [7:0] PKT_RUN_BASE = 8'd127;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] BPP_24       = 8'd24;
    localparam logic [7:0] BPP_32       = 8'd32;

    localparam logic [7:0] TYPE_CMAP     = 8'd1;
    localparam logic [7:0] TYPE_TRUE     = 8'd2;
    localparam logic [7:0] TYPE_CMAP_RLE = 8'd9;
    localparam logic [7:0] TYPE_TRUE_RLE = 8'd10;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_RUN    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [1:0] ERR_SIZE  = 2'd0;
    localparam logic [1:0] ERR_TYPE  = 2'd1;
    localparam logic [1:0] ERR_CMAP  = 2'd2;
    localparam logic [1:0] ERR_DEPTH = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_PACKET,
        PH_PIXEL,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] row;
        logic [15:0] column;
        logic [7:0]  run_length;
        logic [31:0] argb;
        logic        rows_descend;
        logic        image_done;
        logic [1:0]  error_code;
        logic        lookup;
        logic        lookup_hit;
    } result_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [31:0] data;
    } pal_wr_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
    } pal_rd_t;

    typedef struct packed {
        logic        start;
        logic [16:0] pos;
        logic [15:0] width;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [7:0]  quotient;
        logic [15:0] remainder;
    } div_rsp_t;

    function automatic logic [31:0] make_argb(input logic [31:0] raw, input logic [7:0] bpp);
        logic [7:0] alpha;
        alpha = (bpp == BPP_32) ? raw[31:24] : ALPHA_OPAQUE;
        return {alpha, raw[23:0]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tgad_palette_ram.sv @@
// ----------------------------------------------------------------------------
// tgad_palette_ram
// palette store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_palette_ram #(
    parameter int DEPTH = 256
) (
    input  wire logic              clk,
    input  wire tgad_pkg::pal_wr_t wr,
    input  wire tgad_pkg::pal_rd_t rd,
    output logic [31:0]            rd_data
);
    import tgad_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tgad_row_div.sv @@
// ----------------------------------------------------------------------------
// tgad_row_div
// restoring divider for row wrap, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_row_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tgad_pkg::div_req_t req,
    output tgad_pkg::div_rsp_t      rsp
);
    import tgad_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  step_reg, step_next;
    logic [16:0] rem_reg, rem_next;
    logic [23:0] dvs_reg, dvs_next;
    logic [7:0]  quo_reg, quo_next;
    logic [15:0] w_reg, w_next;
    logic [23:0] rem_ext;
    logic [23:0] rem_sub;
    logic        fits;

    always_comb
    begin
        rem_ext   = {7'b0, rem_reg};
        fits      = rem_ext >= dvs_reg;
        rem_sub   = rem_ext - dvs_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        w_next    = w_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = 3'd7;
            rem_next  = req.pos;
            dvs_next  = {1'b0, req.width, 7'b0};
            quo_next  = '0;
            w_next    = req.width;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_sub[16:0];
                quo_next = quo_reg | (8'd1 << step_reg);
            end
            dvs_next  = dvs_reg >> 1;
            step_next = step_reg - 3'd1;
            if (step_reg == 3'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = busy_reg && (step_reg == 3'd0);
    assign rsp.quotient  = quo_next;
    assign rsp.remainder = rem_next[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        w_reg   <= w_next;
    end

`include "assert_macros.svh"
    `TGAD_ASSERT_IMP(a_start_when_idle, req.start, !busy_reg)
    `TGAD_ASSERT_NXT(a_start_loads, req.start, busy_reg && (step_reg == 3'd7))
    `TGAD_ASSERT_IMP(a_rem_below_width, rsp.done, rem_next < {1'b0, w_reg})

endmodule

`default_nettype wire

@@ rtl/core/tgad_parser.sv @@
// ----------------------------------------------------------------------------
// tgad_parser
// header, palette load, packet and pixel parse; builds at most one result per word
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_parser #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    input  wire logic               first_byte,
    input  wire logic               last_byte,
    input  wire tgad_pkg::div_rsp_t div_rsp,
    output tgad_pkg::div_req_t      div_req,
    output tgad_pkg::pal_wr_t       pal_wr,
    output tgad_pkg::pal_rd_t       pal_rd,
    output tgad_pkg::result_t       res,
    output logic                    res_valid
);
    import tgad_pkg::*;

    // registered state
    logic [7:0]  hdr_reg [HDR_LEN];
    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  rem_reg, rem_next;
    logic        run_reg, run_next;
    logic [31:0] asm_reg, asm_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] done_reg, done_next;
    logic [15:0] row_reg, row_next;
    logic [15:0] col_reg, col_next;
    logic        fin_reg, fin_next;
    logic [31:0] total_reg;

    // state as seen by this word (cleared on first_byte)
    phase_t      e_phase;
    logic [4:0]  e_pos;
    logic [7:0]  e_count, e_rem;
    logic        e_run, e_fin;
    logic [31:0] e_asm, e_done;
    logic [1:0]  e_bip;
    logic [15:0] e_row, e_col;

    logic [7:0]  hdr_cur [HDR_LEN];
    logic [7:0]  typ, hdr_bpp;
    logic [15:0] img_w, img_h;
    logic        indexed, packed_data, bottom_cur, bottom_reg, has_cmap;
    logic [31:0] total_prod;

    logic        live, hdr_wr, hdr_evt, hdr_err;
    logic [1:0]  err_code;
    logic [31:0] asm_new;
    logic [2:0]  need;
    logic        elem_done, pal_evt, pal_last, pkt_evt, pix_evt;
    logic [7:0]  run_len, rem_after, clen, idx;
    logic [31:0] left;
    logic        run_fin;
    logic [16:0] pos_sum, wrap_once;
    logic        slow;
    phase_t      data_phase;
    logic [15:0] row_div;

    always_comb
    begin
        e_phase = first_byte ? PH_HEADER : phase_reg;
        e_pos   = first_byte ? '0 : pos_reg;
        e_count = first_byte ? '0 : count_reg;
        e_rem   = first_byte ? '0 : rem_reg;
        e_run   = first_byte ? 1'b0 : run_reg;
        e_fin   = first_byte ? 1'b0 : fin_reg;
        e_asm   = first_byte ? '0 : asm_reg;
        e_done  = first_byte ? '0 : done_reg;
        e_bip   = first_byte ? '0 : bip_reg;
        e_row   = first_byte ? '0 : row_reg;
        e_col   = first_byte ? '0 : col_reg;
    end

    assign live   = !e_fin;
    assign hdr_wr = live && (e_phase == PH_HEADER);

    always_comb
    begin
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_cur[i] = (hdr_wr && (e_pos == 5'(i))) ? data_byte : hdr_reg[i];
        end
    end

    assign typ         = hdr_cur[2];
    assign img_w       = {hdr_cur[13], hdr_cur[12]};
    assign img_h       = {hdr_cur[15], hdr_cur[14]};
    assign indexed     = (typ == TYPE_CMAP) || (typ == TYPE_CMAP_RLE);
    assign packed_data = (typ == TYPE_CMAP_RLE) || (typ == TYPE_TRUE_RLE);
    assign hdr_bpp     = indexed ? hdr_cur[7] : hdr_cur[16];
    assign bottom_cur  = ({hdr_cur[11], hdr_cur[10]} == 16'd0);
    assign bottom_reg  = ({hdr_reg[11], hdr_reg[10]} == 16'd0);
    assign has_cmap    = (hdr_cur[1] != 8'd0) && (hdr_cur[5] != 8'd0);
    assign total_prod  = img_w * img_h;
    assign data_phase  = packed_data ? PH_PACKET : PH_PIXEL;

    // header checks
    always_comb
    begin
        hdr_err  = 1'b1;
        err_code = ERR_SIZE;
        if ((img_w == 16'd0) || (img_h == 16'd0))
        begin
            err_code = ERR_SIZE;
        end
        else if (!(typ inside {TYPE_CMAP, TYPE_TRUE, TYPE_CMAP_RLE, TYPE_TRUE_RLE}))
        begin
            err_code = ERR_TYPE;
        end
        else if (indexed)
        begin
            if ((hdr_cur[6] | hdr_cur[4] | hdr_cur[3]) != 8'd0)
            begin
                err_code = ERR_CMAP;
            end
            else if ((hdr_cur[7] != BPP_24) && (hdr_cur[7] != BPP_32))
            begin
                err_code = ERR_DEPTH;
            end
            else
            begin
                hdr_err = 1'b0;
            end
        end
        else
        begin
            if ((hdr_cur[5] | hdr_cur[6] | hdr_cur[1]) != 8'd0)
            begin
                err_code = ERR_CMAP;
            end
            else if ((hdr_cur[16] != BPP_24) && (hdr_cur[16] != BPP_32))
            begin
                err_code = ERR_DEPTH;
            end
            else
            begin
                hdr_err = 1'b0;
            end
        end
    end

    // event decode
    always_comb
    begin
        hdr_evt   = hdr_wr && (e_pos == 5'(HDR_LEN - 1));
        asm_new   = e_asm | (32'(data_byte) << {e_bip, 3'b000});
        need      = (e_phase == PH_PALETTE) ? hdr_cur[7][5:3]
                  : (indexed ? 3'd1 : hdr_bpp[5:3]);
        elem_done = (({1'b0, e_bip} + 3'd1) >= need);
        pal_evt   = live && (e_phase == PH_PALETTE) && elem_done;
        pal_last  = ({1'b0, e_count} + 9'd1) >= {1'b0, hdr_cur[5]};
        pkt_evt   = live && (e_phase == PH_PACKET);
        pix_evt   = live && (e_phase == PH_PIXEL) && elem_done;
        run_len   = (packed_data && e_run) ? e_rem : 8'd1;
        rem_after = e_rem;
        if (packed_data)
        begin
            if (e_run)
            begin
                rem_after = '0;
            end
            else if (e_rem != 8'd0)
            begin
                rem_after = e_rem - 8'd1;
            end
        end
        left      = total_reg - e_done;
        clen      = (left < 32'(run_len)) ? left[7:0] : run_len;
        run_fin   = (left == 32'(clen));
        pos_sum   = {1'b0, e_col} + 17'(clen);
        wrap_once = pos_sum - {1'b0, img_w};
        slow      = (pos_sum >= {1'b0, img_w}) && (wrap_once >= {1'b0, img_w});
        idx       = asm_new[7:0];
    end

    // next parse phase
    always_comb
    begin
        phase_next = e_phase;
        if (live)
        begin
            case (e_phase)
                PH_HEADER:
                begin
                    if (hdr_evt)
                    begin
                        if (hdr_err)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (indexed && has_cmap)
                        begin
                            phase_next = PH_PALETTE;
                        end
                        else
                        begin
                            phase_next = data_phase;
                        end
                    end
                end
                PH_PALETTE:
                begin
                    if (pal_evt && pal_last)
                    begin
                        phase_next = data_phase;
                    end
                end
                PH_PACKET:
                begin
                    phase_next = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    if (pix_evt)
                    begin
                        if (run_fin)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (packed_data && (rem_after == 8'd0))
                        begin
                            phase_next = PH_PACKET;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
            if (last_byte)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    // datapath next values
    always_comb
    begin
        pos_next   = hdr_wr ? (e_pos + 5'd1) : e_pos;
        count_next = pal_evt ? (e_count + 8'd1) : e_count;
        rem_next   = e_rem;
        run_next   = e_run;
        asm_next   = e_asm;
        bip_next   = e_bip;
        done_next  = e_done;
        row_next   = e_row;
        col_next   = e_col;
        fin_next   = e_fin;

        if (live && ((e_phase == PH_PALETTE) || (e_phase == PH_PIXEL)))
        begin
            asm_next = elem_done ? '0 : asm_new;
            bip_next = elem_done ? '0 : (e_bip + 2'd1);
        end
        if (hdr_evt && !hdr_err)
        begin
            asm_next = '0;
            bip_next = '0;
            col_next = '0;
            row_next = bottom_cur ? (img_h - 16'd1) : 16'd0;
        end
        if (pkt_evt)
        begin
            run_next = (data_byte > PKT_RUN_BASE);
            rem_next = (data_byte > PKT_RUN_BASE) ? (data_byte - PKT_RUN_BASE)
                                                  : (data_byte + 8'd1);
        end
        if (pix_evt)
        begin
            rem_next  = rem_after;
            done_next = e_done + 32'(clen);
            if (pos_sum < {1'b0, img_w})
            begin
                col_next = pos_sum[15:0];
            end
            else if (!slow)
            begin
                col_next = wrap_once[15:0];
                row_next = bottom_cur ? (e_row - 16'd1) : (e_row + 16'd1);
            end
        end
        if (live && ((hdr_evt && hdr_err) || (pix_evt && run_fin) || last_byte
                     || (e_phase == PH_DONE)))
        begin
            fin_next = 1'b1;
        end
    end

    // result and side requests
    always_comb
    begin
        res_valid       = live && (hdr_evt || pix_evt || last_byte);
        res             = '0;
        if (hdr_evt)
        begin
            res.kind = hdr_err ? KIND_ERROR : KIND_HEADER;
        end
        else if (pix_evt)
        begin
            res.kind = KIND_RUN;
        end
        else
        begin
            res.kind = KIND_END;
        end
        if (pos_next == 5'(HDR_LEN))
        begin
            res.width        = img_w;
            res.height       = img_h;
            res.rows_descend = bottom_cur;
        end
        if (pix_evt)
        begin
            res.row        = e_row;
            res.column     = e_col;
            res.run_length = clen;
            res.argb       = indexed ? 32'd0 : make_argb(asm_new, hdr_bpp);
            res.lookup     = indexed;
            res.lookup_hit = (idx < e_count) && ({1'b0, idx} < 9'(PALETTE_DEPTH));
        end
        if (hdr_evt && hdr_err)
        begin
            res.error_code = err_code;
        end
        res.image_done = (hdr_evt && hdr_err) || (pix_evt && run_fin) || (live && last_byte);

        pal_wr.en   = accept && pal_evt && ({1'b0, e_count} < 9'(PALETTE_DEPTH));
        pal_wr.addr = e_count;
        pal_wr.data = make_argb(asm_new, hdr_cur[7]);
        pal_rd.en   = accept;
        pal_rd.addr = idx;

        div_req.start = accept && pix_evt && slow;
        div_req.pos   = pos_sum;
        div_req.width = img_w;
    end

    assign row_div = bottom_reg ? (row_reg - 16'(div_rsp.quotient))
                                : (row_reg + 16'(div_rsp.quotient));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            count_reg <= '0;
            rem_reg   <= '0;
            run_reg   <= 1'b0;
            asm_reg   <= '0;
            bip_reg   <= '0;
            done_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            run_reg   <= run_next;
            asm_reg   <= asm_next;
            bip_reg   <= bip_next;
            done_reg  <= done_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            fin_reg   <= fin_next;
        end
        else if (div_rsp.done)
        begin
            row_reg <= row_div;
            col_reg <= div_rsp.remainder;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HDR_LEN; i++)
        begin
            if (accept && hdr_wr && (e_pos == 5'(i)))
            begin
                hdr_reg[i] <= data_byte;
            end
        end
        if (accept && hdr_evt)
        begin
            total_reg <= total_prod;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tga_image_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tga_image_stream_decoder_core
// streaming tga decoder: header report, errors and pixel runs per file word
// ----------------------------------------------------------------------------
// a result shows on result_valid in the cycle after its word is taken
// one word per cycle while results are taken; a run that wraps two or more rows
//   stalls the input while the row divider works out the new row and column
// the palette read goes through the registered ram port and lands with the result word
// reset: parser starts in header phase, result register and divider empty
`default_nettype none

module tga_image_stream_decoder_core #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       kind,
    output logic [15:0]      width,
    output logic [15:0]      height,
    output logic [15:0]      row,
    output logic [15:0]      column,
    output logic [7:0]       run_length,
    output logic [31:0]      argb,
    output logic             rows_descend,
    output logic             image_done,
    output logic [1:0]       error_code
);
    import tgad_pkg::*;

    logic     accept;
    div_req_t div_req;
    div_rsp_t div_rsp;
    pal_wr_t  pal_wr;
    pal_rd_t  pal_rd;
    logic [31:0] pal_data;
    result_t  res;
    logic     res_valid;

    // output word register
    result_t  res_reg;
    logic     valid_reg;

    // take a word when the result slot is free or draining, and the
    // row divider is not rewriting row and column
    assign byte_ready = !div_rsp.busy && (!valid_reg || result_ready);
    assign accept     = byte_valid && byte_ready;

    tgad_parser #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .first_byte(first_byte),
        .last_byte (last_byte),
        .div_rsp   (div_rsp),
        .div_req   (div_req),
        .pal_wr    (pal_wr),
        .pal_rd    (pal_rd),
        .res       (res),
        .res_valid (res_valid)
    );

    // palette store; entries past the loaded count are masked by the hit flag
    tgad_palette_ram #(
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .clk    (clk),
        .wr     (pal_wr),
        .rd     (pal_rd),
        .rd_data(pal_data)
    );

    // row wrap divider for long runs on narrow images
    tgad_row_div u_row_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= res_valid;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    // indexed pixels take their color from the ram read of the same word
    assign result_valid = valid_reg;
    assign kind         = res_reg.kind;
    assign width        = res_reg.width;
    assign height       = res_reg.height;
    assign row          = res_reg.row;
    assign column       = res_reg.column;
    assign run_length   = res_reg.run_length;
    assign argb         = res_reg.lookup ? (res_reg.lookup_hit ? pal_data : 32'd0)
                                         : res_reg.argb;
    assign rows_descend = res_reg.rows_descend;
    assign image_done   = res_reg.image_done;
    assign error_code   = res_reg.error_code;

`include "assert_macros.svh"
    `TGAD_ASSERT_IMP(a_run_nonempty, valid_reg && (res_reg.kind == KIND_RUN),
                     res_reg.run_length != 8'd0)
    `TGAD_ASSERT_IMP(a_error_ends_file, valid_reg && (res_reg.kind == KIND_ERROR),
                     res_reg.image_done)
    `TGAD_ASSERT_IMP(a_header_nonzero, valid_reg && (res_reg.kind == KIND_HEADER),
                     (res_reg.width != 16'd0) && (res_reg.height != 16'd0))

endmodule

`default_nettype wire

@@ verif/tga_image_stream_decoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// tga_image_stream_decoder_core_tb
// builds tga files byte by byte (headers, palettes, raw and run-length data),
// feeds them through the valid/ready input channel and checks every result
// word against a cycle-free model of the decoder kept inside this bench
// ----------------------------------------------------------------------------
`default_nettype none

module tga_image_stream_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tgad_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // one decoder output word, field for field
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] row;
        logic [15:0] column;
        logic [7:0]  run_length;
        logic [31:0] argb;
        logic        rows_descend;
        logic        image_done;
        logic [1:0]  error_code;
    } tga_word_t;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        result_valid;
    logic        result_ready;
    logic [1:0]  kind;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  run_length;
    logic [31:0] argb;
    logic        rows_descend;
    logic        image_done;
    logic [1:0]  error_code;

    tga_image_stream_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .width        (width),
        .height       (height),
        .row          (row),
        .column       (column),
        .run_length   (run_length),
        .argb         (argb),
        .rows_descend (rows_descend),
        .image_done   (image_done),
        .error_code   (error_code)
    );

    // bench control
    tga_word_t   pending_words[$];
    logic [7:0]  file_q[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    bit          tx_idle_en = 0;
    bit          rx_idle_en = 0;
    int          hold_cnt = 0;

    // decoder state as seen by the bench
    logic [7:0]  hdr[18];
    int          hdr_pos;
    phase_t      phase;
    logic [31:0] pal[256];
    logic [7:0]  pal_cnt;
    logic [7:0]  pkt_left;
    logic        pkt_is_run;
    logic [31:0] pix_acc;
    logic [1:0]  pix_byte;
    logic [31:0] px_done;
    logic [15:0] cur_row;
    logic [15:0] cur_col;
    logic        file_over;

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** tga_image_stream_decoder_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // model of the decoder
    // ------------------------------------------------------------------
    function automatic logic [15:0] hdr_half(input int i);
        return {hdr[i + 1], hdr[i]};
    endfunction

    function automatic bit is_cmapped();
        return hdr[2] == TYPE_CMAP || hdr[2] == TYPE_CMAP_RLE;
    endfunction

    function automatic bit is_rle();
        return hdr[2] == TYPE_CMAP_RLE || hdr[2] == TYPE_TRUE_RLE;
    endfunction

    function automatic bit origin_bottom();
        return hdr_half(10) == 16'd0;
    endfunction

    function automatic logic [7:0] color_bits();
        return is_cmapped() ? hdr[7] : hdr[16];
    endfunction

    // alpha forced opaque unless the color is 32 bits
    function automatic logic [31:0] to_argb(input logic [31:0] raw);
        return {(color_bits() == BPP_32) ? raw[31:24] : ALPHA_OPAQUE, raw[23:0]};
    endfunction

    function automatic void clear_state();
        foreach (hdr[i]) hdr[i] = '0;
        foreach (pal[i]) pal[i] = '0;
        hdr_pos = 0;
        phase = PH_HEADER;
        pal_cnt = '0;
        pkt_left = '0;
        pkt_is_run = 0;
        pix_acc = '0;
        pix_byte = '0;
        px_done = '0;
        cur_row = '0;
        cur_col = '0;
        file_over = 0;
    endfunction

    function automatic void end_file();
        file_over = 1;
        phase = PH_DONE;
    endfunction

    function automatic void start_data();
        pix_byte = '0;
        pix_acc = '0;
        phase = is_rle() ? PH_PACKET : PH_PIXEL;
    endfunction

    function automatic void fill_common(inout tga_word_t wd, input logic [1:0] k);
        wd.kind = k;
        if (hdr_pos >= HDR_LEN)
        begin
            wd.width = hdr_half(12);
            wd.height = hdr_half(14);
            wd.rows_descend = origin_bottom();
        end
    endfunction

    // checks made once the whole header is in
    function automatic void check_header(inout tga_word_t wd);
        bit         bad;
        logic [1:0] code;
        bad = 1;
        code = ERR_SIZE;
        if (hdr_half(12) == 0 || hdr_half(14) == 0)
            code = ERR_SIZE;
        else if (!(hdr[2] inside {TYPE_CMAP, TYPE_TRUE, TYPE_CMAP_RLE, TYPE_TRUE_RLE}))
            code = ERR_TYPE;
        else if (is_cmapped())
        begin
            if (hdr[6] != 0 || hdr[4] != 0 || hdr[3] != 0)
                code = ERR_CMAP;
            else if (hdr[7] != BPP_24 && hdr[7] != BPP_32)
                code = ERR_DEPTH;
            else
                bad = 0;
        end
        else
        begin
            if (hdr[5] != 0 || hdr[6] != 0 || hdr[1] != 0)
                code = ERR_CMAP;
            else if (hdr[16] != BPP_24 && hdr[16] != BPP_32)
                code = ERR_DEPTH;
            else
                bad = 0;
        end
        if (bad)
        begin
            fill_common(wd, KIND_ERROR);
            wd.image_done = 1;
            wd.error_code = code;
            end_file();
            return;
        end
        fill_common(wd, KIND_HEADER);
        cur_col = '0;
        cur_row = origin_bottom() ? hdr_half(14) - 16'd1 : 16'd0;
        if (is_cmapped() && hdr[1] != 0 && hdr[5] != 0)
        begin
            phase = PH_PALETTE;
            pix_byte = '0;
            pix_acc = '0;
        end
        else
            start_data();
    endfunction

    // one run of pixels, clipped to what is left of the image
    function automatic void put_run(inout tga_word_t wd, input logic [31:0] px,
                                    input longint len);
        longint wid;
        longint total;
        longint pos;
        longint rows;
        wid = hdr_half(12);
        total = wid * longint'(hdr_half(14));
        if (len > total - px_done)
            len = total - px_done;
        fill_common(wd, KIND_RUN);
        wd.row = cur_row;
        wd.column = cur_col;
        wd.run_length = len[7:0];
        wd.argb = px;
        pos = longint'(cur_col) + len;
        rows = pos / wid;
        cur_col = 16'(pos % wid);
        if (origin_bottom())
            cur_row = cur_row - 16'(rows);
        else
            cur_row = cur_row + 16'(rows);
        px_done = px_done + 32'(len);
        if (longint'(px_done) >= total)
        begin
            wd.image_done = 1;
            end_file();
        end
    endfunction

    // advance the model by one accepted word and queue what it must produce
    function automatic void decode_byte(input logic [7:0] b, input logic first,
                                        input logic last);
        tga_word_t   wd;
        bit          have;
        bit          live;
        int          need;
        logic [31:0] px;
        longint      len;
        logic [7:0]  idx;
        wd = '0;
        have = 0;
        if (first)
            clear_state();
        live = !file_over;
        if (live)
        begin
            case (phase)
                PH_HEADER:
                begin
                    if (hdr_pos < HDR_LEN)
                        hdr[hdr_pos] = b;
                    hdr_pos++;
                    if (hdr_pos >= HDR_LEN)
                    begin
                        hdr_pos = HDR_LEN;
                        check_header(wd);
                        have = 1;
                    end
                end
                PH_PALETTE:
                begin
                    need = hdr[7] >> 3;
                    pix_acc |= 32'(b) << (8 * pix_byte);
                    if (int'(pix_byte) + 1 < need)
                        pix_byte++;
                    else
                    begin
                        pal[pal_cnt] = to_argb(pix_acc);
                        pal_cnt++;
                        pix_byte = '0;
                        pix_acc = '0;
                        if (pal_cnt >= hdr[5])
                            start_data();
                    end
                end
                PH_PACKET:
                begin
                    // high bit set: one pixel repeated, else a literal packet
                    if (b > PKT_RUN_BASE)
                    begin
                        pkt_is_run = 1;
                        pkt_left = b - PKT_RUN_BASE;
                    end
                    else
                    begin
                        pkt_is_run = 0;
                        pkt_left = b + 8'd1;
                    end
                    phase = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    need = is_cmapped() ? 1 : (color_bits() >> 3);
                    pix_acc |= 32'(b) << (8 * pix_byte);
                    if (int'(pix_byte) + 1 < need)
                        pix_byte++;
                    else
                    begin
                        pix_byte = '0;
                        if (is_cmapped())
                        begin
                            idx = pix_acc[7:0];
                            // index past the loaded palette reads as zero
                            px = (idx < pal_cnt) ? pal[idx] : 32'd0;
                        end
                        else
                            px = to_argb(pix_acc);
                        pix_acc = '0;
                        len = 1;
                        if (is_rle())
                        begin
                            if (pkt_is_run)
                            begin
                                len = pkt_left;
                                pkt_left = '0;
                            end
                            else if (pkt_left > 0)
                                pkt_left--;
                        end
                        put_run(wd, px, len);
                        have = 1;
                        if (!file_over && is_rle() && pkt_left == 0)
                            phase = PH_PACKET;
                    end
                end
                default: end_file();
            endcase
        end
        if (live && last)
        begin
            if (!have)
            begin
                fill_common(wd, KIND_END);
                have = 1;
            end
            wd.image_done = 1;
            end_file();
        end
        if (have)
            pending_words.push_back(wd);
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tga_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word, kind %0d", kind);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    fail_count++;
                end
                if (width !== want.width)
                begin
                    $error("width: expected %0d, got %0d", want.width, width);
                    fail_count++;
                end
                if (height !== want.height)
                begin
                    $error("height: expected %0d, got %0d", want.height, height);
                    fail_count++;
                end
                if (row !== want.row)
                begin
                    $error("row: expected %0d, got %0d", want.row, row);
                    fail_count++;
                end
                if (column !== want.column)
                begin
                    $error("column: expected %0d, got %0d", want.column, column);
                    fail_count++;
                end
                if (run_length !== want.run_length)
                begin
                    $error("run_length: expected %0d, got %0d", want.run_length,
                           run_length);
                    fail_count++;
                end
                if (argb !== want.argb)
                begin
                    $error("argb: expected %h, got %h", want.argb, argb);
                    fail_count++;
                end
                if (rows_descend !== want.rows_descend)
                begin
                    $error("rows_descend: expected %0d, got %0d", want.rows_descend,
                           rows_descend);
                    fail_count++;
                end
                if (image_done !== want.image_done)
                begin
                    $error("image_done: expected %0d, got %0d", want.image_done,
                           image_done);
                    fail_count++;
                end
                if (error_code !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d", want.error_code,
                           error_code);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: long hold-offs take priority over random stall bursts
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result_ready <= 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                result_ready <= 0;
            end
            else
                result_ready <= 1;
        end
    end

    // ------------------------------------------------------------------
    // word sender: returns at a falling edge with valid still high
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            byte_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1;
        data_byte <= b;
        first_byte <= first;
        last_byte <= last;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        decode_byte(b, first, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_file(input bit mark_first, input bit mark_last);
        foreach (file_q[i])
            send_byte(file_q[i], mark_first && i == 0,
                      mark_last && i == file_q.size() - 1);
    endtask

    // header, palette and pixel data for one file into file_q
    task automatic build_file(input logic [7:0] img_type, input logic [7:0] bpp,
                              input int wid, input int hgt, input bit bottom,
                              input int ncmap);
        bit   cmapped;
        bit   rle;
        int   px;
        int   cnt;
        bit   run;
        int   ent;
        logic [15:0] yorg;
        cmapped = img_type == TYPE_CMAP || img_type == TYPE_CMAP_RLE;
        rle = img_type == TYPE_CMAP_RLE || img_type == TYPE_TRUE_RLE;
        yorg = bottom ? 16'd0 : 16'($urandom_range(1, 65535));
        file_q.delete();
        file_q.push_back(8'($urandom));                       // id length, not skipped
        file_q.push_back(cmapped && ncmap > 0 ? 8'd1 : 8'd0);
        file_q.push_back(img_type);
        file_q.push_back(8'd0);
        file_q.push_back(8'd0);
        file_q.push_back(cmapped ? 8'(ncmap) : 8'd0);
        file_q.push_back(8'd0);
        file_q.push_back(cmapped ? bpp : 8'($urandom));
        file_q.push_back(8'($urandom));
        file_q.push_back(8'($urandom));
        file_q.push_back(yorg[7:0]);
        file_q.push_back(yorg[15:8]);
        file_q.push_back(wid[7:0]);
        file_q.push_back(wid[15:8]);
        file_q.push_back(hgt[7:0]);
        file_q.push_back(hgt[15:8]);
        file_q.push_back(cmapped ? 8'($urandom) : bpp);
        file_q.push_back(8'($urandom));
        if (cmapped)
            for (ent = 0; ent < ncmap * (bpp / 8); ent++)
                file_q.push_back(8'($urandom));
        px = 0;
        while (px < wid * hgt && px < 400)
        begin
            cnt = 1;
            run = 0;
            if (rle)
            begin
                run = $urandom_range(0, 1);
                cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128)
                                                 : $urandom_range(1, 6);
                file_q.push_back(run ? 8'(cnt + 127) : 8'(cnt - 1));
            end
            px += cnt;
            repeat (run ? 1 : cnt)
            begin
                if (cmapped)
                    file_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                     : 8'($urandom_range(0, ncmap + 2)));
                else
                    repeat (bpp / 8) file_q.push_back(8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // right out of reset the stream is taken as a file even without a mark
    task automatic test_unmarked_start();
        build_file(TYPE_TRUE, BPP_24, 2, 2, 0, 0);
        send_file(0, 1);
    endtask

    task automatic test_header_errors();
        build_file(TYPE_TRUE, BPP_24, 0, 3, 1, 0);            // zero width
        send_file(1, 0);
        build_file(TYPE_TRUE, BPP_24, 4, 0, 1, 0);            // zero height
        file_q = file_q[0:17];
        send_file(1, 0);
        build_file(8'd3, BPP_24, 2, 2, 1, 0);                 // unknown type
        file_q = file_q[0:17];
        send_file(1, 1);
        build_file(TYPE_TRUE_RLE, BPP_32, 2, 2, 1, 0);        // truecolor with map length
        file_q[5] = 8'd4;
        file_q = file_q[0:17];
        send_file(1, 0);
        build_file(TYPE_CMAP, BPP_24, 2, 2, 1, 2);            // map origin nonzero
        file_q[3] = 8'h80;
        file_q = file_q[0:17];
        send_file(1, 0);
        build_file(TYPE_CMAP_RLE, 8'd16, 2, 2, 1, 2);         // map entry depth
        file_q = file_q[0:17];
        send_file(1, 0);
        build_file(TYPE_TRUE, 8'd8, 2, 2, 0, 0);              // pixel depth
        file_q = file_q[0:17];
        send_file(1, 0);
        // words after an error are dropped, last mark included
        send_byte(8'hFF, 0, 0);
        send_byte(8'h00, 0, 1);
    endtask

    task automatic test_formats();
        build_file(TYPE_TRUE, BPP_24, 3, 2, 0, 0);
        send_file(1, 0);
        build_file(TYPE_TRUE, BPP_32, 3, 3, 1, 0);
        send_file(1, 0);
        build_file(TYPE_CMAP, BPP_24, 4, 2, 1, 3);            // indices past palette
        send_file(1, 0);
        build_file(TYPE_CMAP_RLE, BPP_32, 5, 3, 0, 4);
        send_file(1, 0);
        build_file(TYPE_CMAP, BPP_32, 3, 1, 0, 0);            // no palette at all
        send_file(1, 0);
        build_file(TYPE_TRUE_RLE, BPP_24, 7, 4, 1, 0);
        file_q.push_back(8'hFF);                              // long run gets clipped
        file_q.push_back(8'h12);
        file_q.push_back(8'h34);
        file_q.push_back(8'h56);
        send_file(1, 1);
        build_file(TYPE_CMAP, BPP_24, 2, 1, 1, 16);           // larger palette
        send_file(1, 0);
    endtask

    task automatic test_early_end();
        build_file(TYPE_TRUE, BPP_32, 4, 4, 1, 0);            // last on header byte
        file_q = file_q[0:17];
        send_file(1, 1);
        build_file(TYPE_TRUE, BPP_32, 4, 4, 0, 0);            // last inside a pixel
        file_q = file_q[0:19];
        send_file(1, 1);
        build_file(TYPE_TRUE_RLE, BPP_24, 4, 4, 0, 0);        // last on a run result
        file_q = file_q[0:21];
        send_file(1, 1);
        build_file(TYPE_TRUE_RLE, BPP_32, 65535, 1, 0, 0);    // widest image, cut short
        file_q = file_q[0:40];
        send_file(1, 1);
        build_file(TYPE_TRUE, BPP_24, 1, 65535, 1, 0);        // tallest, bottom-up
        file_q = file_q[0:35];
        send_file(1, 1);
    endtask

    task automatic random_file();
        logic [7:0] t;
        int sel;
        int cut;
        sel = $urandom_range(0, 3);
        t = (sel == 0) ? TYPE_CMAP : (sel == 1) ? TYPE_TRUE :
            (sel == 2) ? TYPE_CMAP_RLE : TYPE_TRUE_RLE;
        build_file(t, $urandom_range(0, 1) ? BPP_32 : BPP_24, $urandom_range(1, 12),
                   $urandom_range(1, 6), $urandom_range(0, 1), $urandom_range(0, 8));
        sel = $urandom_range(0, 19);
        if (sel == 0)
            file_q[$urandom_range(0, 17)] = 8'($urandom);     // corrupted header
        if (sel == 1)
        begin
            cut = $urandom_range(0, file_q.size() - 1);
            file_q = file_q[0:cut];
        end
        if (sel == 2)
            repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom));
        send_file(sel != 3, sel == 1 || $urandom_range(0, 3) == 0);
    endtask

    task automatic test_random();
        tx_idle_en = 1;
        rx_idle_en = 1;
        repeat (2) random_file();
    endtask

    // hold results back so the core fills and stops taking words
    task automatic test_backpressure();
        hold_cnt = 300;
        build_file(TYPE_TRUE_RLE, BPP_32, 4, 4, 0, 0);
        send_file(1, 0);
        build_file(TYPE_TRUE, BPP_24, 3, 3, 1, 0);
        send_file(1, 0);
        // sender waits until every word has come back
        byte_valid <= 0;
        @(negedge clk);
        while (pending_words.size() != 0)
            @(negedge clk);
        build_file(TYPE_CMAP_RLE, BPP_24, 4, 2, 1, 3);
        send_file(1, 0);
    endtask

    task automatic test_full_rate();
        tx_idle_en = 0;
        rx_idle_en = 0;
        repeat (2) random_file();
    endtask

    initial
    begin
        rst_n = 0;
        byte_valid = 0;
        data_byte = '0;
        first_byte = 0;
        last_byte = 0;
        clear_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        test_unmarked_start();
        test_header_errors();
        test_formats();
        test_early_end();
        test_random();
        test_backpressure();
        test_full_rate();

        byte_valid <= 0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** tga_image_stream_decoder_core: PASSED **");
        else
            $display("** tga_image_stream_decoder_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
